>>> hw/rtl/gllc_pkg.sv
package gllc_pkg;

  // Payload widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LINE_W   = 31;
  localparam int unsigned CSUM_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LNUM_W   = 32;

  // Characters of interest
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_N     = 8'h4E;

  // Transaction kinds on the input channel
  localparam logic OP_RX_BYTE   = 1'b0;
  localparam logic OP_LOAD_LINE = 1'b1;

  typedef enum logic [1:0] {
    KIND_BLANK    = 2'd0,
    KIND_COMMENT  = 2'd1,
    KIND_NUMBERED = 2'd2,
    KIND_PLAIN    = 2'd3
  } line_kind_t;

  typedef enum logic [1:0] {
    NUM_LEAD = 2'd0,
    NUM_POS  = 2'd1,
    NUM_NEG  = 2'd2,
    NUM_DONE = 2'd3
  } num_phase_t;

  typedef enum logic [1:0] {
    STAR_LEAD   = 2'd0,
    STAR_DIGITS = 2'd1,
    STAR_DONE   = 2'd2
  } star_phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LINE  = 2'd1,
    ST_NO_CSUM   = 2'd2,
    ST_CSUM_BAD  = 2'd3
  } status_t;

endpackage

>>> hw/rtl/gllc_in_if.sv
interface gllc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [gllc_pkg::BYTE_W-1:0]       rx_byte;
  logic [gllc_pkg::LINE_W-1:0]       line_value;

  modport source (output valid, operation, rx_byte, line_value, input ready);
  modport sink   (input valid, operation, rx_byte, line_value, output ready);
endinterface

>>> hw/rtl/gllc_out_if.sv
interface gllc_out_if;
  logic                              valid;
  logic                              ready;
  logic [gllc_pkg::STATUS_W-1:0]     status;
  logic [gllc_pkg::BYTE_W-1:0]       computed_checksum;
  logic [gllc_pkg::CSUM_W-1:0]       sent_checksum;
  logic [gllc_pkg::LINE_W-1:0]       expected_line;

  modport source (output valid, status, computed_checksum, sent_checksum, expected_line,
                  input ready);
  modport sink   (input valid, status, computed_checksum, sent_checksum, expected_line,
                  output ready);
endinterface

>>> hw/rtl/gcode_line_number_checksum_check.sv
// G-code line number and checksum checker.
//
// in_ch carries one transaction per received byte (operation 0) or a load of
// the expected line number (operation 1, takes effect at once). A CR or LF
// byte closes the line; a closed line that is neither blank nor a ';' comment
// yields one transaction on out_ch with the status, the XOR of the bytes
// before the last '*', the decimal checksum after it and the expected line
// number after the line. cfg_we/cfg_wdata write strict mode (1 after reset).
//
// Throughput is one transaction per cycle while the receiver takes results: each
// byte updates the line state with one shift-add step, and the result of a line
// terminator lands in the output register at the accepting edge.
// in_ch.ready stays high while the output register is empty or being taken;
// when the receiver stalls with a result pending, in_ch.ready drops until the
// result is taken.
// Synchronous reset clears the partial line, sets the expected line number
// to 0, selects strict mode and empties the output register.
module gcode_line_number_checksum_check #(
  parameter int unsigned MAX_LINE = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  gllc_in_if.sink            in_ch,
  gllc_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(MAX_LINE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_LINE - 1);

  localparam logic signed [35:0] LNUM_MAX = 36'sd2147483647;
  localparam logic signed [35:0] LNUM_MIN = -36'sd2147483648;

  // Line state
  logic                                   strict_r;
  logic [CNT_W-1:0]                       cnt_r, cnt_nxt;
  logic [gllc_pkg::BYTE_W-1:0]            xor_r, xor_nxt;
  logic [gllc_pkg::BYTE_W-1:0]            xor_star_r, xor_star_nxt;
  logic                                   star_seen_r, star_seen_nxt;
  logic [gllc_pkg::CSUM_W-1:0]            star_num_r, star_num_nxt;
  gllc_pkg::star_phase_t                  star_ph_r, star_ph_nxt;
  gllc_pkg::line_kind_t                   kind_r, kind_nxt;
  logic signed [gllc_pkg::LNUM_W-1:0]     lnum_r, lnum_nxt;
  gllc_pkg::num_phase_t                   num_ph_r, num_ph_nxt;
  logic [gllc_pkg::LINE_W-1:0]            exp_r, exp_nxt;
  logic                                   ended_r, ended_nxt;

  // Output register
  logic                                   out_valid_r, out_valid_nxt;
  gllc_pkg::status_t                      out_status_r, out_status_nxt;
  logic [gllc_pkg::BYTE_W-1:0]            out_csum_r, out_csum_nxt;
  logic [gllc_pkg::CSUM_W-1:0]            out_sent_r, out_sent_nxt;
  logic [gllc_pkg::LINE_W-1:0]            out_exp_r, out_exp_nxt;

  logic                                   in_fire;
  logic [gllc_pkg::BYTE_W-1:0]            rx_b;
  logic                                   is_dig;
  logic                                   is_term;
  logic [3:0]                             dig;
  logic signed [35:0]                     lnum_w, lnum_pos, lnum_neg;
  logic signed [gllc_pkg::LNUM_W-1:0]     lnum_pos_sat, lnum_neg_sat;
  logic [19:0]                            star_acc;
  logic [gllc_pkg::CSUM_W-1:0]            star_acc_sat;
  gllc_pkg::status_t                      status_w;
  logic [gllc_pkg::LINE_W-1:0]            exp_after;

  // Handshake: a new transaction enters when the output slot is free or leaving
  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.computed_checksum = out_csum_r;
  assign out_ch.sent_checksum     = out_sent_r;
  assign out_ch.expected_line     = out_exp_r;

  // Byte classification
  assign rx_b    = in_ch.rx_byte;
  assign is_dig  = rx_b inside {[gllc_pkg::CH_ZERO:gllc_pkg::CH_NINE]};
  assign is_term = (rx_b == gllc_pkg::CH_CR) || (rx_b == gllc_pkg::CH_LF);
  assign dig     = rx_b[3:0];

  // Line number accumulate with saturation to the signed 32-bit range
  assign lnum_w   = 36'(lnum_r);
  assign lnum_pos = (lnum_w <<< 3) + (lnum_w <<< 1) + $signed({32'b0, dig});
  assign lnum_neg = (lnum_w <<< 3) + (lnum_w <<< 1) - $signed({32'b0, dig});
  assign lnum_pos_sat = (lnum_pos > LNUM_MAX) ? LNUM_MAX[31:0] : lnum_pos[31:0];
  assign lnum_neg_sat = (lnum_neg < LNUM_MIN) ? LNUM_MIN[31:0] : lnum_neg[31:0];

  // Checksum accumulate, saturating at 16 bits
  assign star_acc     = (20'(star_num_r) << 3) + (20'(star_num_r) << 1) + 20'(dig);
  assign star_acc_sat = (star_acc[19:16] != 4'd0) ? '1 : star_acc[15:0];

  // Line verdict at the terminator
  always_comb begin
    status_w  = gllc_pkg::ST_OK;
    exp_after = exp_r;
    if (strict_r) begin
      if (kind_r == gllc_pkg::KIND_NUMBERED) begin
        if (lnum_r != $signed({1'b0, exp_r})) begin
          status_w = gllc_pkg::ST_BAD_LINE;
        end else begin
          exp_after = exp_r + 1'b1;
        end
      end
      if (status_w == gllc_pkg::ST_OK) begin
        if (!star_seen_r) begin
          status_w = gllc_pkg::ST_NO_CSUM;
        end else if ({8'b0, xor_star_r} != star_num_r) begin
          status_w = gllc_pkg::ST_CSUM_BAD;
        end
      end
    end
  end

  // Next state of the line and the output register
  always_comb begin
    cnt_nxt        = cnt_r;
    xor_nxt        = xor_r;
    xor_star_nxt   = xor_star_r;
    star_seen_nxt  = star_seen_r;
    star_num_nxt   = star_num_r;
    star_ph_nxt    = star_ph_r;
    kind_nxt       = kind_r;
    lnum_nxt       = lnum_r;
    num_ph_nxt     = num_ph_r;
    exp_nxt        = exp_r;
    ended_nxt      = ended_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_csum_nxt   = out_csum_r;
    out_sent_nxt   = out_sent_r;
    out_exp_nxt    = out_exp_r;

    if (in_fire) begin
      if (in_ch.operation == gllc_pkg::OP_LOAD_LINE) begin
        exp_nxt = in_ch.line_value;
      end else if (!is_term) begin
        // Content byte, kept only while the line has room and no NUL was seen
        if (!ended_r && cnt_r != CNT_LAST) begin
          if (rx_b == gllc_pkg::CH_NUL) begin
            ended_nxt = 1'b1;
          end else begin
            if (cnt_r == '0) begin
              if (rx_b == gllc_pkg::CH_SEMI) begin
                kind_nxt = gllc_pkg::KIND_COMMENT;
              end else if (rx_b == gllc_pkg::CH_N) begin
                kind_nxt = gllc_pkg::KIND_NUMBERED;
              end else begin
                kind_nxt = gllc_pkg::KIND_PLAIN;
              end
            end else if (kind_r == gllc_pkg::KIND_NUMBERED) begin
              case (num_ph_r)
                gllc_pkg::NUM_LEAD: begin
                  if (rx_b == gllc_pkg::CH_SPACE) begin
                    num_ph_nxt = gllc_pkg::NUM_LEAD;
                  end else if (rx_b == gllc_pkg::CH_PLUS) begin
                    num_ph_nxt = gllc_pkg::NUM_POS;
                  end else if (rx_b == gllc_pkg::CH_MINUS) begin
                    num_ph_nxt = gllc_pkg::NUM_NEG;
                  end else if (is_dig) begin
                    num_ph_nxt = gllc_pkg::NUM_POS;
                    lnum_nxt   = lnum_pos_sat;
                  end else begin
                    num_ph_nxt = gllc_pkg::NUM_DONE;
                  end
                end
                gllc_pkg::NUM_POS: begin
                  if (is_dig) lnum_nxt = lnum_pos_sat;
                  else        num_ph_nxt = gllc_pkg::NUM_DONE;
                end
                gllc_pkg::NUM_NEG: begin
                  if (is_dig) lnum_nxt = lnum_neg_sat;
                  else        num_ph_nxt = gllc_pkg::NUM_DONE;
                end
                default: begin
                  num_ph_nxt = num_ph_r;
                end
              endcase
            end

            // Checksum field after the last star
            if (rx_b == gllc_pkg::CH_STAR) begin
              xor_star_nxt  = xor_r;
              star_seen_nxt = 1'b1;
              star_num_nxt  = '0;
              star_ph_nxt   = gllc_pkg::STAR_LEAD;
            end else if (star_seen_r) begin
              case (star_ph_r)
                gllc_pkg::STAR_LEAD,
                gllc_pkg::STAR_DIGITS: begin
                  if (star_ph_r == gllc_pkg::STAR_LEAD && rx_b == gllc_pkg::CH_SPACE) begin
                    star_ph_nxt = gllc_pkg::STAR_LEAD;
                  end else if (!is_dig) begin
                    star_ph_nxt = gllc_pkg::STAR_DONE;
                  end else begin
                    star_ph_nxt  = gllc_pkg::STAR_DIGITS;
                    star_num_nxt = star_acc_sat;
                  end
                end
                default: begin
                  star_ph_nxt = star_ph_r;
                end
              endcase
            end

            xor_nxt = xor_r ^ rx_b;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end else begin
        // Terminator: report non-blank, non-comment lines, then start over
        if (kind_r == gllc_pkg::KIND_NUMBERED || kind_r == gllc_pkg::KIND_PLAIN) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_w;
          out_csum_nxt   = star_seen_r ? xor_star_r : '0;
          out_sent_nxt   = star_seen_r ? star_num_r : '0;
          out_exp_nxt    = exp_after;
          exp_nxt        = exp_after;
        end
        cnt_nxt       = '0;
        xor_nxt       = '0;
        xor_star_nxt  = '0;
        star_seen_nxt = 1'b0;
        star_num_nxt  = '0;
        star_ph_nxt   = gllc_pkg::STAR_LEAD;
        kind_nxt      = gllc_pkg::KIND_BLANK;
        lnum_nxt      = '0;
        num_ph_nxt    = gllc_pkg::NUM_LEAD;
        ended_nxt     = 1'b0;
      end
    end
  end

  // Control and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r    <= 1'b1;
      cnt_r       <= '0;
      xor_r       <= '0;
      xor_star_r  <= '0;
      star_seen_r <= 1'b0;
      star_num_r  <= '0;
      star_ph_r   <= gllc_pkg::STAR_LEAD;
      kind_r      <= gllc_pkg::KIND_BLANK;
      lnum_r      <= '0;
      num_ph_r    <= gllc_pkg::NUM_LEAD;
      exp_r       <= '0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) strict_r <= cfg_wdata;
      cnt_r       <= cnt_nxt;
      xor_r       <= xor_nxt;
      xor_star_r  <= xor_star_nxt;
      star_seen_r <= star_seen_nxt;
      star_num_r  <= star_num_nxt;
      star_ph_r   <= star_ph_nxt;
      kind_r      <= kind_nxt;
      lnum_r      <= lnum_nxt;
      num_ph_r    <= num_ph_nxt;
      exp_r       <= exp_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_csum_r   <= out_csum_nxt;
    out_sent_r   <= out_sent_nxt;
    out_exp_r    <= out_exp_nxt;
  end

`ifndef NO_ASSERTIONS
  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output register not empty after reset");

  // Kept byte count never passes the line limit
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST)
    else $error("byte count beyond line limit");

  // A new result only follows an accepted transaction
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire))
    else $error("result without accepted transaction");

  // A load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.operation == gllc_pkg::OP_LOAD_LINE) |=> !$rose(out_valid_r))
    else $error("load produced a result");

  // In non-strict mode every reported line is ok
  a_lenient_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !strict_r && in_ch.operation == gllc_pkg::OP_RX_BYTE && is_term &&
     (kind_r == gllc_pkg::KIND_NUMBERED || kind_r == gllc_pkg::KIND_PLAIN))
    |=> (out_valid_r && out_status_r == gllc_pkg::ST_OK))
    else $error("non-strict line reported an error");
`endif

endmodule

>>> tb/sv/tb_gcode_line_number_checksum_check.sv
module tb_gcode_line_number_checksum_check;
  import gllc_pkg::*;

  localparam int LINE_CAP = 64;

  // One input transaction and one predicted line verdict
  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] data;
    logic [LINE_W-1:0] value;
  } rx_item_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] xsum;
    logic [CSUM_W-1:0] sent;
    logic [LINE_W-1:0] next_line;
  } line_verdict_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  gllc_in_if  in_ch();
  gllc_out_if out_ch();

  gcode_line_number_checksum_check #(.MAX_LINE(LINE_CAP)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rx_item_t      rx_items_q[$];
  line_verdict_t pending_verdicts[$];
  logic [7:0]    line_bytes[$];
  int            items_pushed = 0;
  int            mismatches = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  logic          in_fired = 1'b0;

  // Line checker state as the block holds it
  logic              strict_on = 1'b1;
  logic [LINE_W-1:0] exp_line_nr = '0;
  int                kept_count;
  logic [7:0]        line_xor;
  logic [7:0]        star_xor;
  logic              star_found;
  int                csum_value;
  star_phase_t       csum_phase;
  line_kind_t        kind;
  longint            line_nr;
  num_phase_t        nr_phase;
  logic              content_done;

  // Stimulus side shadow of the expected line number
  logic [LINE_W-1:0] gen_line = '0;
  logic              gen_strict = 1'b1;

  task automatic reset_line_state();
    kept_count   = 0;
    line_xor     = '0;
    star_xor     = '0;
    star_found   = 1'b0;
    csum_value   = 0;
    csum_phase   = STAR_LEAD;
    kind         = KIND_BLANK;
    line_nr      = 0;
    nr_phase     = NUM_LEAD;
    content_done = 1'b0;
  endtask

  function automatic logic is_dec(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // Signed line number after 'N', saturated to 32 bits
  task automatic parse_line_digit(input logic [7:0] b);
    longint d;
    d = longint'(b) - longint'(CH_ZERO);
    if (nr_phase == NUM_LEAD) begin
      if (b == CH_SPACE) return;
      if (b == CH_PLUS) begin
        nr_phase = NUM_POS;
        return;
      end
      if (b == CH_MINUS) begin
        nr_phase = NUM_NEG;
        return;
      end
      nr_phase = NUM_POS;
    end
    if (nr_phase == NUM_DONE) return;
    if (!is_dec(b)) begin
      nr_phase = NUM_DONE;
      return;
    end
    if (nr_phase == NUM_POS) begin
      line_nr = line_nr * 10 + d;
      if (line_nr > 64'sd2147483647) line_nr = 64'sd2147483647;
    end else begin
      line_nr = line_nr * 10 - d;
      if (line_nr < -64'sd2147483648) line_nr = -64'sd2147483648;
    end
  endtask

  // Decimal checksum after the last star, saturated at 65535
  task automatic parse_csum_digit(input logic [7:0] b);
    int t;
    if (csum_phase == STAR_DONE) return;
    if (csum_phase == STAR_LEAD && b == CH_SPACE) return;
    if (!is_dec(b)) begin
      csum_phase = STAR_DONE;
      return;
    end
    csum_phase = STAR_DIGITS;
    t = csum_value * 10 + int'(b - CH_ZERO);
    csum_value = (t > 65535) ? 65535 : t;
  endtask

  // Apply one accepted transaction; a closed line queues its verdict
  task automatic advance_line_checker(input logic op, input logic [7:0] b,
                                      input logic [LINE_W-1:0] v);
    line_verdict_t r;
    status_t       st;
    if (op == OP_LOAD_LINE) begin
      exp_line_nr = v;
      return;
    end
    if (b != CH_CR && b != CH_LF) begin
      if (content_done || kept_count >= LINE_CAP - 1) return;
      if (b == CH_NUL) begin
        content_done = 1'b1;
        return;
      end
      if (kept_count == 0) begin
        if (b == CH_SEMI) kind = KIND_COMMENT;
        else if (b == CH_N) kind = KIND_NUMBERED;
        else kind = KIND_PLAIN;
      end else if (kind == KIND_NUMBERED) begin
        parse_line_digit(b);
      end
      if (b == CH_STAR) begin
        star_xor   = line_xor;
        star_found = 1'b1;
        csum_value = 0;
        csum_phase = STAR_LEAD;
      end else if (star_found) begin
        parse_csum_digit(b);
      end
      line_xor = line_xor ^ b;
      kept_count++;
      return;
    end
    // Terminator: blank and comment lines are silent
    if (kind == KIND_BLANK || kind == KIND_COMMENT) begin
      reset_line_state();
      return;
    end
    st = ST_OK;
    if (strict_on) begin
      if (kind == KIND_NUMBERED) begin
        if (line_nr != longint'(exp_line_nr)) st = ST_BAD_LINE;
        else exp_line_nr = exp_line_nr + 1'b1;
      end
      if (st == ST_OK) begin
        if (!star_found) st = ST_NO_CSUM;
        else if (16'(star_xor) != csum_value[15:0]) st = ST_CSUM_BAD;
      end
    end
    r.status    = st;
    r.xsum      = star_found ? star_xor : '0;
    r.sent      = star_found ? csum_value[15:0] : '0;
    r.next_line = exp_line_nr;
    pending_verdicts.push_back(r);
    reset_line_state();
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, want %0d at %0t", field, got, want, $time);
    mismatches++;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: presents queued transactions and the receiver's ready at the falling edge
  always @(negedge clk) begin
    rx_item_t it;
    if (rst_n) begin
      if (!in_ch.valid || in_fired) begin
        if (rx_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          it = rx_items_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.operation  <= it.op;
          in_ch.rx_byte    <= it.data;
          in_ch.line_value <= it.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: checks results, then predicts from the accepted input
  always @(posedge clk) begin
    line_verdict_t want;
    in_fired <= in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("unexpected result, status", out_ch.status, -1);
        end else begin
          want = pending_verdicts.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", out_ch.status, want.status);
          if (out_ch.computed_checksum !== want.xsum)
            report_mismatch("computed_checksum", out_ch.computed_checksum, want.xsum);
          if (out_ch.sent_checksum !== want.sent)
            report_mismatch("sent_checksum", out_ch.sent_checksum, want.sent);
          if (out_ch.expected_line !== want.next_line)
            report_mismatch("expected_line", out_ch.expected_line, want.next_line);
        end
      end
      if (in_ch.valid && in_ch.ready)
        advance_line_checker(in_ch.operation, in_ch.rx_byte, in_ch.line_value);
    end
  end

  // Stimulus helpers
  task automatic push_item(input logic op, input logic [7:0] b, input logic [LINE_W-1:0] v);
    rx_item_t it;
    it.op    = op;
    it.data  = b;
    it.value = v;
    rx_items_q.push_back(it);
    items_pushed++;
  endtask

  task automatic push_load(input logic [LINE_W-1:0] v);
    push_item(OP_LOAD_LINE, 8'($urandom), v);
    gen_line = v;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] built_xor();
    logic [7:0] x;
    x = '0;
    foreach (line_bytes[i]) x = x ^ line_bytes[i];
    return x;
  endfunction

  // Sends the built bytes, then CR, LF or CR LF
  task automatic flush_line();
    int t;
    foreach (line_bytes[i]) push_item(OP_RX_BYTE, line_bytes[i], 31'($urandom));
    t = $urandom_range(9);
    if (t == 0) begin
      push_item(OP_RX_BYTE, CH_CR, 31'($urandom));
      push_item(OP_RX_BYTE, CH_LF, 31'($urandom));
    end else begin
      push_item(OP_RX_BYTE, (t < 5) ? CH_CR : CH_LF, 31'($urandom));
    end
    line_bytes.delete();
  endtask

  function automatic logic [7:0] body_char();
    string      set;
    logic [7:0] b;
    set = "G0123456789 XYZEFM.-;N+";
    if ($urandom_range(9) == 0) begin
      b = 8'($urandom_range(1, 255));
      if (b == CH_CR || b == CH_LF) b = b | 8'h80;
      return b;
    end
    return set[$urandom_range(set.len() - 1)];
  endfunction

  // One random line or a load of the line number: mostly well formed commands, some noise and broken ones
  task automatic emit_random_line();
    int         pick;
    int         sel;
    int         n;
    logic       nr_ok;
    logic [7:0] x;
    line_bytes.delete();
    pick = $urandom_range(99);
    if (pick < 5) begin
      sel = $urandom_range(2);
      if (sel == 0) push_load(31'($urandom_range(0, 20)));
      else if (sel == 1) push_load(31'h7FFF_FFFF - 31'($urandom_range(0, 3)));
      else push_load(31'($urandom));
      return;
    end
    if (pick < 11) begin
      n = $urandom_range(1, 10);
      repeat (n) push_item(OP_RX_BYTE, 8'($urandom), 31'($urandom));
      flush_line();
      return;
    end
    if (pick < 17) begin
      add_text(";");
      repeat ($urandom_range(0, 6)) line_bytes.push_back(body_char());
      flush_line();
      return;
    end
    if (pick < 21) begin
      flush_line();
      return;
    end
    // Line number part
    nr_ok = 1'b0;
    if ($urandom_range(99) < 75) begin
      add_text("N");
      if ($urandom_range(9) == 0) add_text("  ");
      sel = $urandom_range(99);
      if (sel < 75) begin
        if ($urandom_range(9) == 0) add_text("+");
        add_text($sformatf("%0d", gen_line));
        nr_ok = 1'b1;
      end else if (sel < 85) begin
        add_text($sformatf("%0d", longint'(gen_line) + 1 + $urandom_range(5)));
      end else if (sel < 92) begin
        if ($urandom_range(1) == 0) add_text($sformatf("-%0d", $urandom_range(1, 99999)));
        else add_text("-99999999999");
      end else begin
        add_text("99999999999");
      end
      add_text(" ");
    end
    // Command body, possibly with an earlier star
    n = $urandom_range(0, 12);
    repeat (n) line_bytes.push_back(body_char());
    if ($urandom_range(19) == 0) add_text("*7 G");
    if ($urandom_range(24) == 0) begin
      line_bytes.push_back(CH_NUL);
      add_text("G9");
    end
    if ($urandom_range(24) == 0) begin
      n = $urandom_range(58, 75);
      while (line_bytes.size() < n) add_text("X");
    end
    // Checksum part
    x = built_xor();
    sel = $urandom_range(99);
    if (sel < 78) begin
      add_text("*");
      if ($urandom_range(9) == 0) add_text(" ");
      add_text($sformatf("%0d", x));
    end else if (sel < 86) begin
      add_text($sformatf("*%0d", int'(x) + 1 + $urandom_range(300)));
    end else if (sel < 90) begin
      add_text(($urandom_range(1) == 0) ? "*99999" : "*123456");
    end else if (sel < 94) begin
      add_text("*G");
    end
    if ($urandom_range(9) == 0) add_text(" ;x");
    flush_line();
    if (nr_ok && gen_strict) gen_line = gen_line + 1'b1;
  endtask

  // Block has drained: nothing queued, nothing presented, nothing owed
  task automatic wait_idle();
    while (rx_items_q.size() != 0 || in_ch.valid || pending_verdicts.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_strict(input logic v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    strict_on  = v;
    gen_strict = v;
  endtask

  // Main sequence
  initial begin
    int chunk_start;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_RX_BYTE;
    in_ch.rx_byte    = '0;
    in_ch.line_value = '0;
    out_ch.ready     = 1'b0;
    reset_line_state();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: blank, comment, max load with wrap, high and zero bytes
    push_item(OP_RX_BYTE, CH_LF, '0);
    add_text(";");
    flush_line();
    push_item(OP_LOAD_LINE, 8'hFF, 31'h7FFF_FFFF);
    add_text("N2147483647");
    add_text($sformatf("*%0d", built_xor()));
    flush_line();
    push_item(OP_RX_BYTE, 8'hFF, 31'h7FFF_FFFF);
    push_item(OP_RX_BYTE, CH_NUL, '0);
    push_item(OP_RX_BYTE, CH_STAR, '0);
    push_item(OP_RX_BYTE, CH_CR, '0);
    push_item(OP_LOAD_LINE, 8'h00, '0);
    gen_line = '0;
    wait_idle();

    // Random phases with different idling and strict settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          write_strict(1'b1);
        end
        1: begin
          send_idle_pct = 51;
          recv_stall_pct = 0;
          write_strict(1'b1);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 51;
          write_strict(1'b0);
        end
        default: begin
          send_idle_pct = 7;
          recv_stall_pct = 7;
          write_strict(1'b1);
        end
      endcase
      repeat (4) begin
        chunk_start = items_pushed;
        while (items_pushed - chunk_start < 22) emit_random_line();
        wait_idle();
      end
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/gllc_pkg.sv
hw/rtl/gllc_in_if.sv
hw/rtl/gllc_out_if.sv
hw/rtl/gcode_line_number_checksum_check.sv
tb/sv/tb_gcode_line_number_checksum_check.sv
